// ----- rtl/core/voxel_frustum_visibility_test_assert.svh -----
// Assertion helpers for the frustum test RTL.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef VOXEL_FRUSTUM_VISIBILITY_TEST_ASSERT_SVH
`define VOXEL_FRUSTUM_VISIBILITY_TEST_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define VFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define VFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/vft_pkg.sv -----
package vft_pkg;

  localparam int MAX_GRID_SIDE = 1024;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int COORD_W       = 16;
  localparam int FRAC_W        = 15;
  localparam int NUM_AXES      = 3;
  localparam int NUM_ROWS      = 4;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int NUM_STEPS     = FRAC_W;

  // Largest count that still matters once the count field is clipped.
  localparam logic [CNT_W-1:0] GRID_CAP =
      (MAX_GRID_SIDE > 2047) ? CNT_W'(2047) : CNT_W'(MAX_GRID_SIDE);
  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL0   = 3'd0,
    REG_COL1   = 3'd1,
    REG_COL2   = 3'd2,
    REG_COL3   = 3'd3,
    REG_DEPTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_WIDTH  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] index_first;
    logic [IDX_W-1:0] index_second;
    logic [IDX_W-1:0] index_third;
    logic             last_in;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic [COORD_W-1:0] coord_first;
    logic [COORD_W-1:0] coord_second;
    logic [COORD_W-1:0] coord_third;
    logic               last_out;
  } out_item_t;

  // Classified item waiting between front and back.
  typedef struct packed {
    logic [NUM_AXES-1:0][IDX_W-1:0] idx;
    logic [NUM_AXES-1:0]            sat;
    logic                           last;
  } queue_item_t;

  typedef logic [NUM_AXES-1:0][CNT_W-1:0] divisor_t;

  // One lane of the restoring divider: partial remainder, and a shift word
  // that feeds dividend bits out at the top and takes quotient bits in.
  typedef struct packed {
    logic [CNT_W-1:0]  rem;
    logic [FRAC_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NUM_AXES-1:0] lane;
    logic [NUM_AXES-1:0]      sat;
    logic                     last;
  } div_stage_t;

  // max(1, min(count, cap) - 1)
  function automatic logic [CNT_W-1:0] divisor_of(logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] c;
    c = (count > GRID_CAP) ? GRID_CAP : count;
    return (c > CNT_W'(1)) ? c - CNT_W'(1) : CNT_W'(1);
  endfunction

  function automatic div_lane_t div_step(div_lane_t a, logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    div_lane_t      r;
    t     = {a.rem, a.quo[FRAC_W-1]};
    r.quo = {a.quo[FRAC_W-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem    = CNT_W'(t - {1'b0, d});
      r.quo[0] = 1'b1;
    end else begin
      r.rem = t[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/vft_front.sv -----
module vft_front import vft_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  input  divisor_t    divisor_i,
  input  logic        full_i,
  output logic        push_o,
  output queue_item_t push_data_o
);

  logic [NUM_AXES-1:0][IDX_W-1:0] idx;

  assign idx = {in_data_i.index_third, in_data_i.index_second, in_data_i.index_first};

  // Flag indices at or past the last grid position: they clamp to 1.0.
  always_comb begin
    push_data_o.idx  = idx;
    push_data_o.last = in_data_i.last_in;
    for (int a = 0; a < NUM_AXES; a++) begin
      push_data_o.sat[a] = {1'b0, idx[a]} >= divisor_i[a];
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ----- rtl/core/vft_queue.sv -----
module vft_queue import vft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  queue_item_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        head_valid_o,
  output queue_item_t head_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t      mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0] level_q;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o       = level_q == LVL_W'(QUEUE_DEPTH);
  assign head_valid_o = level_q != '0;
  assign head_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      unique case ({push_i, pop_i})
        2'b10:   level_q <= level_q + LVL_W'(1);
        2'b01:   level_q <= level_q - LVL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- rtl/core/vft_back.sv -----
module vft_back import vft_pkg::*; #(
  parameter int COEFF_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  queue_item_t                       head_data_i,
  output logic                              pop_o,
  input  divisor_t                          divisor_i,
  input  logic [NUM_ROWS-1:0][CFG_W-1:0]    columns_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output out_item_t                         out_data_o
);

  `include "voxel_frustum_visibility_test_assert.svh"

  localparam int EXT_W  = NUM_ROWS * COEFF_BITS;
  localparam int PROD_W = COEFF_BITS + COORD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CMP_W  = SUM_W + 1;

  logic adv;

  // Divider stages: one quotient bit per stage.
  logic [NUM_STEPS-1:0] div_v_q;
  div_stage_t           div_q  [NUM_STEPS];
  div_stage_t           div_in [NUM_STEPS];
  div_stage_t           div_d  [NUM_STEPS];
  logic [NUM_AXES-1:0][COORD_W-1:0] div_coord;

  // Product stage.
  logic                             prod_v_q;
  logic signed [PROD_W-1:0]         prod_d [NUM_ROWS][NUM_AXES];
  logic signed [PROD_W-1:0]         prod_q [NUM_ROWS][NUM_AXES];
  logic [NUM_AXES-1:0][COORD_W-1:0] prod_coord_q;
  logic                             prod_last_q;

  // Row sum stage.
  logic                             sum_v_q;
  logic signed [SUM_W-1:0]          sum_d [NUM_ROWS];
  logic signed [SUM_W-1:0]          sum_q [NUM_ROWS];
  logic [NUM_AXES-1:0][COORD_W-1:0] sum_coord_q;
  logic                             sum_last_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic [NUM_ROWS-1:0][EXT_W-1:0] col_ext;
  logic signed [COEFF_BITS-1:0]   coef [NUM_ROWS][NUM_ROWS];
  logic signed [CMP_W-1:0]        cx, cy, cz, cw, ncw;

  // Hold the whole pipe while a finished beat waits downstream.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  // Coefficient lanes; lanes past the top of a column read as zero.
  always_comb begin
    for (int c = 0; c < NUM_ROWS; c++) begin
      col_ext[c] = EXT_W'(columns_i[c]);
      for (int r = 0; r < NUM_ROWS; r++) begin
        coef[c][r] = col_ext[c][r*COEFF_BITS +: COEFF_BITS];
      end
    end
  end

  always_comb begin
    div_in[0].sat  = head_data_i.sat;
    div_in[0].last = head_data_i.last;
    for (int a = 0; a < NUM_AXES; a++) begin
      div_in[0].lane[a].rem = CNT_W'(head_data_i.idx[a]);
      div_in[0].lane[a].quo = FRAC_W'(divisor_i[a] >> 1);
    end
    for (int s = 1; s < NUM_STEPS; s++) begin
      div_in[s] = div_q[s-1];
    end
    for (int s = 0; s < NUM_STEPS; s++) begin
      div_d[s] = div_in[s];
      for (int a = 0; a < NUM_AXES; a++) begin
        div_d[s].lane[a] = div_step(div_in[s].lane[a], divisor_i[a]);
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      div_coord[a] = div_q[NUM_STEPS-1].sat[a] ? COORD_ONE
                                               : {1'b0, div_q[NUM_STEPS-1].lane[a].quo};
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_d[r][a] = PROD_W'(coef[a][r]) * PROD_W'($signed({1'b0, div_coord[a]}));
      end
    end
  end

  // Translation column times 1.0 is a shift.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_d[r] = (SUM_W'(coef[NUM_ROWS-1][r]) <<< FRAC_W)
               + SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
    end
  end

  // Clip test against w in place of the perspective divide.
  always_comb begin
    cx  = CMP_W'(sum_q[0]);
    cy  = CMP_W'(sum_q[1]);
    cz  = CMP_W'(sum_q[2]);
    cw  = CMP_W'(sum_q[3]);
    ncw = -cw;
    out_d.visible      = (cw > 0) && (cx >= ncw) && (cx <= cw) && (cy >= ncw) && (cy <= cw)
                      && (cz >= 0) && (cz <= cw);
    out_d.coord_first  = sum_coord_q[0];
    out_d.coord_second = sum_coord_q[1];
    out_d.coord_third  = sum_coord_q[2];
    out_d.last_out     = sum_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q     <= '0;
      prod_v_q    <= 1'b0;
      sum_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      div_v_q     <= {div_v_q[NUM_STEPS-2:0], head_valid_i};
      prod_v_q    <= div_v_q[NUM_STEPS-1];
      sum_v_q     <= prod_v_q;
      out_valid_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NUM_STEPS; s++) begin
        div_q[s] <= div_d[s];
      end
      prod_q       <= prod_d;
      prod_coord_q <= div_coord;
      prod_last_q  <= div_q[NUM_STEPS-1].last;
      sum_q        <= sum_d;
      sum_coord_q  <= prod_coord_q;
      sum_last_q   <= prod_last_q;
      out_q        <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `VFT_ASSERT_NEXT(a_sum_to_out, adv && sum_v_q, out_valid_q,
                   "summed beat did not reach the output register")
  `VFT_ASSERT_NEXT(a_stall_freeze, !adv,
                   $stable(div_v_q) && $stable(prod_v_q) && $stable(sum_v_q),
                   "pipeline moved during an output stall")
  `VFT_ASSERT_NOW(a_coord_range, out_valid_q,
                  (!out_q.coord_first[FRAC_W] || out_q.coord_first[FRAC_W-1:0] == '0)
                  && (!out_q.coord_second[FRAC_W] || out_q.coord_second[FRAC_W-1:0] == '0)
                  && (!out_q.coord_third[FRAC_W] || out_q.coord_third[FRAC_W-1:0] == '0),
                  "normalized coordinate above 1.0")

endmodule

// ----- rtl/core/voxel_frustum_visibility_test.sv -----
// Path: queue entry written on accept, 15 divider stages, 3 math stages (product, sum, output).
// Throughput: one voxel per cycle unless the output stalls; one quotient bit per divider stage.
// A stalled output freezes the back pipeline; the 2-entry queue then fills and stalls input.
// Reset: matrix cleared to zero, all three counts set to one, queue and pipeline emptied.
// Config writes take effect on the next cycle and are expected only while idle.
module voxel_frustum_visibility_test import vft_pkg::*; #(
  parameter int COEFF_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input beats: one voxel index triple each
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  // output beats: one per input beat, in order
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [NUM_ROWS-1:0][CFG_W-1:0] columns_q;
  logic [NUM_AXES-1:0][CNT_W-1:0] counts_q;
  divisor_t                       divisor;

  logic        full, push, pop, head_valid;
  queue_item_t push_data, head_data;

  // Register file: four packed matrix columns and three axis counts.
  // Unknown indices are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        counts_q[a] <= CNT_W'(1);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COL0:   columns_q[0] <= cfg_data_i;
        REG_COL1:   columns_q[1] <= cfg_data_i;
        REG_COL2:   columns_q[2] <= cfg_data_i;
        REG_COL3:   columns_q[3] <= cfg_data_i;
        REG_DEPTH:  counts_q[0]  <= cfg_data_i[CNT_W-1:0];
        REG_HEIGHT: counts_q[1]  <= cfg_data_i[CNT_W-1:0];
        REG_WIDTH:  counts_q[2]  <= cfg_data_i[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Per-axis divisor max(1, count-1), count clipped to the grid limit.
  // Shared by the front (clamp flags) and the back (divider).
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      divisor[a] = divisor_of(counts_q[a]);
    end
  end

  // Front: take a beat and flag out-of-range indices.
  vft_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .divisor_i   (divisor),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Short queue decouples input acceptance from output stalls.
  vft_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  // Back: normalize, project through the matrix, clip test, register result.
  vft_back #(
    .COEFF_BITS (COEFF_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .divisor_i    (divisor),
    .columns_i    (columns_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ----- sim/tb_voxel_frustum_visibility_test.sv -----
module tb_voxel_frustum_visibility_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vft_pkg::*;

  // Coefficient lane width; the block is built with its default.
  localparam int LANE_W = 16;
  // Idle time after draining, longer than the block's pipeline, before touching registers.
  localparam int SETTLE_CYCLES = 24;
  // Bound on waiting for outstanding results before calling them lost.
  localparam int DRAIN_LIMIT = 6000;
  localparam int NUM_PHASES = 11;
  localparam int BEATS_PER_PHASE = 100;
  // Phase in which the receiver holds off long enough to fill the block.
  localparam int PRESSURE_PHASE = 3;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int GAP_LIMIT = 18;
  // No register lives at this index; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint unsigned UNIT_ONE = 64'd32768;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i   = '0;

  voxel_frustum_visibility_test #(
    .COEFF_BITS (LANE_W)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the register file, kept in step with every write.
  logic [CFG_W-1:0] matrix_col [NUM_ROWS];
  logic [CNT_W-1:0] grid_count [NUM_AXES];

  // Results the block owes us, oldest first.
  out_item_t pending_results[$];

  int unsigned err_count     = 0;
  int unsigned beats_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned visible_seen  = 0;
  int unsigned settings_used = 0;

  // Per-phase idle limits for both sides, and the one-shot long stall request.
  int unsigned tx_gap_max  = 0;
  int unsigned rx_gap_max  = 0;
  bit          squeeze_req = 1'b0;

  // One step of the directed script: either a register write or a voxel beat,
  // the latter optionally with its result typed in by hand.
  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_data;
    in_item_t             beat;
    bit                   typed;
    out_item_t            want;
  } stim_row_t;

  stim_row_t script[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Divisor of one axis: max(1, min(count, cap) - 1).
  function automatic longint unsigned axis_span(logic [CNT_W-1:0] count);
    longint unsigned c;
    c = (count > MAX_GRID_SIDE) ? longint'(MAX_GRID_SIDE) : longint'(count);
    return (c > 1) ? c - 1 : 1;
  endfunction

  // Index to Q1.15 centre coordinate, round half up, saturate at 1.0.
  function automatic logic [COORD_W-1:0] unit_coord(logic [IDX_W-1:0] idx,
                                                    logic [CNT_W-1:0] count);
    longint unsigned span;
    longint unsigned q;
    span = axis_span(count);
    if (longint'(idx) >= span) return COORD_ONE;
    q = (longint'(idx) * UNIT_ONE + span / 2) / span;
    return (q > UNIT_ONE) ? COORD_ONE : COORD_W'(q);
  endfunction

  function automatic longint lane_coeff(logic [CFG_W-1:0] col, int row);
    return longint'($signed(col[row*LANE_W +: LANE_W]));
  endfunction

  // Project the voxel centre and test it against the clip volume, using w in
  // place of the perspective divide.
  function automatic out_item_t predict_voxel(in_item_t beat);
    out_item_t r;
    longint    pos  [NUM_AXES];
    longint    clip [NUM_ROWS];
    r.coord_first  = unit_coord(beat.index_first,  grid_count[0]);
    r.coord_second = unit_coord(beat.index_second, grid_count[1]);
    r.coord_third  = unit_coord(beat.index_third,  grid_count[2]);
    r.last_out     = beat.last_in;
    pos[0] = longint'(r.coord_first);
    pos[1] = longint'(r.coord_second);
    pos[2] = longint'(r.coord_third);
    for (int row = 0; row < NUM_ROWS; row++) begin
      clip[row] = lane_coeff(matrix_col[3], row) * longint'(UNIT_ONE);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        clip[row] += lane_coeff(matrix_col[ax], row) * pos[ax];
      end
    end
    r.visible = (clip[3] > 0)
             && (clip[0] >= -clip[3]) && (clip[0] <= clip[3])
             && (clip[1] >= -clip[3]) && (clip[1] <= clip[3])
             && (clip[2] >= 0)        && (clip[2] <= clip[3]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Compare one delivered result beat against the oldest one owed.
  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t ns: result beat with nothing expected, expected none, got %p",
               $time, got);
      err_count++;
      return;
    end
    want = pending_results.pop_front();
    report_field("visible",      want.visible,      got.visible);
    report_field("coord_first",  want.coord_first,  got.coord_first);
    report_field("coord_second", want.coord_second, got.coord_second);
    report_field("coord_third",  want.coord_third,  got.coord_third);
    report_field("last_out",     want.last_out,     got.last_out);
    beats_checked++;
    if (got.visible) visible_seen++;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [CFG_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CFG_W-1:0] pack_lanes(int r0, int r1, int r2, int r3);
    return {LANE_W'(r3), LANE_W'(r2), LANE_W'(r1), LANE_W'(r0)};
  endfunction

  // Write one register; the shadow copy takes the value at the same time.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (cfg_reg_e'(idx))
      REG_COL0:   matrix_col[0] = value;
      REG_COL1:   matrix_col[1] = value;
      REG_COL2:   matrix_col[2] = value;
      REG_COL3:   matrix_col[3] = value;
      REG_DEPTH:  grid_count[0] = value[CNT_W-1:0];
      REG_HEIGHT: grid_count[1] = value[CNT_W-1:0];
      REG_WIDTH:  grid_count[2] = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one voxel beat after a random gap and hold it until accepted.
  // Return at the accepting edge with valid still high, so that a follow-up
  // beat with no gap keeps valid asserted without a glitch.
  task automatic offer_voxel(in_item_t beat, bit typed, out_item_t want);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_results.insert(pending_results.size(), typed ? want : predict_voxel(beat));
    beats_sent++;
  endtask

  // Drop valid, wait for every owed result, then let the pipeline go quiet.
  task automatic settle_block();
    int unsigned guard;
    in_valid_i <= 1'b0;
    for (guard = 0; guard < DRAIN_LIMIT && pending_results.size() != 0; guard++) begin
      @(posedge clk_i);
    end
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected 0 outstanding, got %0d",
               $time, pending_results.size(), pending_results.size());
      err_count++;
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Directed script builders
  // ---------------------------------------------------------------------------

  // Append one row at the end of the directed script.
  function automatic void add_row(stim_row_t r);
    script.insert(script.size(), r);
  endfunction

  function automatic stim_row_t voxel_row(int a, int b, int c, bit last);
    stim_row_t r;
    r = '{default: '0};
    r.beat.index_first  = IDX_W'(a);
    r.beat.index_second = IDX_W'(b);
    r.beat.index_third  = IDX_W'(c);
    r.beat.last_in      = last;
    return r;
  endfunction

  function automatic stim_row_t known_row(int a, int b, int c, bit last, bit vis,
                                          int ca, int cb, int cc);
    stim_row_t r;
    r = voxel_row(a, b, c, last);
    r.typed             = 1'b1;
    r.want.visible      = vis;
    r.want.coord_first  = COORD_W'(ca);
    r.want.coord_second = COORD_W'(cb);
    r.want.coord_third  = COORD_W'(cc);
    r.want.last_out     = last;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    stim_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = value;
    return r;
  endfunction

  function automatic void build_script();
    // Reset state: zero matrix means w = 0, so nothing is visible; counts of
    // one give divisor one, so index zero lands on 0.0 and anything else on 1.0.
    add_row(known_row(0,    0,    0,    0, 0, 0,     0,     0));
    add_row(known_row(1023, 1023, 1023, 1, 0, 32768, 32768, 32768));
    add_row(known_row(1,    0,    682,  0, 0, 32768, 0,     32768));
    add_row(known_row(0,    1023, 0,    1, 0, 0,     32768, 0));

    // Map the unit cube onto the clip volume: x' = 2x - 1, y' = 2y - 1,
    // z' = z, w = 1. Depth count written with junk above the count field,
    // width count of zero.
    add_row(reg_row(REG_COL0, 64'h0000_0000_0000_0800));
    add_row(reg_row(REG_COL1, 64'h0000_0000_0800_0000));
    add_row(reg_row(REG_COL2, 64'h0000_0400_0000_0000));
    add_row(reg_row(REG_COL3, 64'h0400_0000_FC00_FC00));
    add_row(reg_row(REG_DEPTH,  64'hFFFF_FFFF_FFFF_F400));
    add_row(reg_row(REG_HEIGHT, 64'd3));
    add_row(reg_row(REG_WIDTH,  64'h0000_8000_0000_0000));
    add_row(voxel_row(0,    0, 0, 0));
    add_row(voxel_row(1023, 2, 7, 1));
    add_row(voxel_row(511,  1, 0, 0));
    add_row(voxel_row(512,  1, 0, 1));
    add_row(voxel_row(1,    2, 1, 0));
    add_row(voxel_row(1022, 0, 0, 0));

    // Count above the cap, a write to the unused index, and extreme translation
    // lanes in the last column.
    add_row(reg_row(REG_DEPTH,  64'h7FF));
    add_row(reg_row(REG_SPARE,  '1));
    add_row(reg_row(REG_HEIGHT, 64'd2));
    add_row(reg_row(REG_COL3,   64'h7FFF_8000_7FFF_8000));
    add_row(voxel_row(1023, 1, 1023, 1));
    add_row(voxel_row(0,    0, 0,    0));
    add_row(voxel_row(700,  1, 300,  0));
    add_row(voxel_row(1000, 0, 5,    1));

    // Negative w, then w of exactly zero: both must read as not visible.
    add_row(reg_row(REG_COL3, 64'h8000_0000_0000_0000));
    add_row(voxel_row(5, 1, 0, 0));
    add_row(reg_row(REG_COL3, 64'h0));
    add_row(voxel_row(3, 0, 1, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Random settings
  // ---------------------------------------------------------------------------

  // Count field value with junk above it: zero, one, small, mid, the cap,
  // and values past the cap all show up.
  function automatic logic [CFG_W-1:0] pick_count();
    logic [CFG_W-1:0] junk;
    int unsigned      count;
    junk = rand_word();
    case ($urandom_range(0, 7))
      0:       count = 0;
      1:       count = 1;
      2:       count = 2;
      3:       count = $urandom_range(3, 16);
      4:       count = $urandom_range(1, 1024);
      5:       count = 1024;
      6:       count = $urandom_range(1025, 2047);
      default: count = 2047;
    endcase
    return {junk[CFG_W-1:CNT_W], CNT_W'(count)};
  endfunction

  function automatic int pick_extreme_lane();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return 0;
    endcase
  endfunction

  // One matrix column. Style 0 is raw noise, style 1 lane extremes, and the
  // rest a rough view transform so a fair share of voxels end up inside.
  function automatic logic [CFG_W-1:0] pick_column(int style, int col);
    int lane [NUM_ROWS];
    if (style == 0) return rand_word();
    for (int row = 0; row < NUM_ROWS; row++) begin
      if (style == 1) begin
        lane[row] = pick_extreme_lane();
      end else if (col == 3) begin
        lane[row] = (row == 3) ? rand_between(256, 2048) : rand_between(-3072, 3072);
      end else if (row == 3) begin
        lane[row] = rand_between(-128, 128);
      end else if (row == col) begin
        lane[row] = ($urandom_range(0, 1) ? 1 : -1) * rand_between(1024, 4096);
      end else begin
        lane[row] = rand_between(-256, 256);
      end
    end
    return pack_lanes(lane[0], lane[1], lane[2], lane[3]);
  endfunction

  // Mostly in-range indices so coordinates spread over the grid, with a
  // quarter drawn over the whole field to hit saturation and every bit.
  function automatic logic [IDX_W-1:0] pick_index(logic [CNT_W-1:0] count);
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, int'(axis_span(count))));
  endfunction

  function automatic int unsigned pick_gap_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return GAP_LIMIT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: one draw of idle cycles per beat; the long stall is counted
  // here when the stimulus asks for it.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        if (squeeze_req) begin
          squeeze_req = 1'b0;
          hold_left   = SQUEEZE_CYCLES;
        end else begin
          hold_left = $urandom_range(0, rx_gap_max);
        end
        out_ready_i <= (hold_left == 0);
      end else if (!out_ready_i) begin
        if (hold_left > 0) hold_left--;
        if (hold_left == 0) out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t  beat;
    out_item_t none;
    int        style;

    none = '0;
    for (int i = 0; i < NUM_ROWS; i++) matrix_col[i] = '0;
    for (int i = 0; i < NUM_AXES; i++) grid_count[i] = CNT_W'(1);
    build_script();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: moderate gaps on both sides.
    tx_gap_max = 3;
    rx_gap_max = 3;
    settings_used++;
    foreach (script[i]) begin
      if (script[i].is_write) begin
        settle_block();
        write_reg(script[i].reg_idx, script[i].reg_data);
        settings_used++;
      end else begin
        offer_voxel(script[i].beat, script[i].typed, script[i].want);
      end
    end
    settle_block();

    // Random part: a fresh register setting per phase, then a run of beats.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      style = (ph < 2) ? ph : ((ph % 4 == 0) ? 0 : 2);
      for (int col = 0; col < NUM_ROWS; col++) begin
        write_reg(CFG_IDX_W'(col), pick_column(style, col));
      end
      // Pin the first two phases to the count extremes: at or past the cap, then zero or one.
      write_reg(REG_DEPTH,  (ph == 0) ? 64'h7FF : (ph == 1) ? 64'd1 : pick_count());
      write_reg(REG_HEIGHT, (ph == 0) ? 64'h7FF : (ph == 1) ? 64'd0 : pick_count());
      write_reg(REG_WIDTH,  (ph == 0) ? 64'h400 : (ph == 1) ? 64'd1 : pick_count());
      write_reg(REG_SPARE, rand_word());
      settings_used++;

      tx_gap_max = pick_gap_limit();
      rx_gap_max = pick_gap_limit();
      if (ph == PRESSURE_PHASE) begin
        // Keep offering back to back while the sink sits out a long stall.
        tx_gap_max  = 0;
        squeeze_req = 1'b1;
      end

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        beat.index_first  = pick_index(grid_count[0]);
        beat.index_second = pick_index(grid_count[1]);
        beat.index_third  = pick_index(grid_count[2]);
        beat.last_in      = (n == BEATS_PER_PHASE - 1) || ($urandom_range(0, 15) == 0);
        offer_voxel(beat, 1'b0, none);
      end
      settle_block();
    end

    $display("Run covered %0d voxel beats over %0d register settings.",
             beats_sent, settings_used);
    $display("Checked %0d result beats, %0d of them visible, %0d mismatches.",
             beats_checked, visible_seen, err_count);
    if (err_count == 0 && beats_checked == beats_sent) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #2ms;
    $display("Timeout after %0t ns with %0d results outstanding.",
             $time, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
